// ===== hw/rtl/mrw_pkg.sv =====
// Types, constants and a helper function shared by the modem response watcher.
package mrw_pkg;

  localparam logic [3:0] MaxPattern  = 4'd8;
  localparam logic [2:0] ErrLen      = 3'd5;
  localparam logic [7:0] NewlineChar = 8'h0A;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdByte  = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhMatch   = 2'd1,
    PhCapture = 2'd2,
    PhDone    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StBusy    = 3'd1,
    StMatched = 3'd2,
    StError   = 3'd3,
    StTimeout = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CfgPatChars = 2'd0,
    CfgPatLen   = 2'd1,
    CfgTimeout  = 2'd2,
    CfgCapLimit = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] pattern_chars;
    logic [3:0]  pattern_length;
    logic [31:0] timeout_ticks;
    logic [7:0]  capture_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] capture_byte;
    logic       capture_valid;
  } res_t;

  // Characters of the fixed word "ERROR".
  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h45;
      3'd1:    ch = 8'h52;
      3'd2:    ch = 8'h52;
      3'd3:    ch = 8'h4F;
      3'd4:    ch = 8'h52;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/mrw_cfg.sv =====
// Configuration register file of the modem response watcher.
module mrw_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output mrw_pkg::cfg_t      cfg_o
);

  mrw_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mrw_pkg::cfg_idx_e'(cfg_index_i))
        mrw_pkg::CfgPatChars: cfg_d.pattern_chars  = cfg_data_i;
        mrw_pkg::CfgPatLen:   cfg_d.pattern_length = cfg_data_i[3:0];
        mrw_pkg::CfgTimeout:  cfg_d.timeout_ticks  = cfg_data_i[31:0];
        mrw_pkg::CfgCapLimit: cfg_d.capture_limit  = cfg_data_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_chars  <= 64'd0;
      cfg_q.pattern_length <= 4'd1;
      cfg_q.timeout_ticks  <= 32'd0;
      cfg_q.capture_limit  <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/mrw_core.sv =====
// Watcher state and the combinational per-item update: pattern and ERROR matchers, capture, timer.
module mrw_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [1:0]    command_i,
  input  logic [7:0]    rx_byte_i,
  input  mrw_pkg::cfg_t cfg_i,
  output mrw_pkg::res_t res_o
);

  mrw_pkg::phase_e phase_q, phase_d;
  logic [3:0]  match_index_q, match_index_d;
  logic [2:0]  error_index_q, error_index_d;
  logic [31:0] ticks_left_q, ticks_left_d;
  logic [7:0]  captured_count_q, captured_count_d;
  logic [2:0]  final_status_q, final_status_d;

  logic [3:0]  eff_len;
  logic [7:0]  pat_cur;
  logic [7:0]  pat_first;
  logic [3:0]  mi;
  logic [2:0]  ei;
  logic [7:0]  cnt_inc;
  logic [31:0] ticks_dec;
  logic [7:0]  cap_byte;
  logic        cap_valid;

  assign eff_len   = (cfg_i.pattern_length > mrw_pkg::MaxPattern) ? mrw_pkg::MaxPattern
                                                                  : cfg_i.pattern_length;
  assign pat_cur   = cfg_i.pattern_chars[{match_index_q[2:0], 3'b000} +: 8];
  assign pat_first = cfg_i.pattern_chars[7:0];
  assign cnt_inc   = captured_count_q + 8'd1;
  assign ticks_dec = ticks_left_q - 32'd1;

  always_comb begin
    if (match_index_q < mrw_pkg::MaxPattern && rx_byte_i == pat_cur) begin
      mi = match_index_q + 4'd1;
    end else if (rx_byte_i == pat_first) begin
      mi = 4'd1;
    end else begin
      mi = 4'd0;
    end
    if (error_index_q < mrw_pkg::ErrLen && rx_byte_i == mrw_pkg::err_char(error_index_q)) begin
      ei = error_index_q + 3'd1;
    end else if (rx_byte_i == mrw_pkg::err_char(3'd0)) begin
      ei = 3'd1;
    end else begin
      ei = 3'd0;
    end
  end

  always_comb begin
    phase_d          = phase_q;
    match_index_d    = match_index_q;
    error_index_d    = error_index_q;
    ticks_left_d     = ticks_left_q;
    captured_count_d = captured_count_q;
    final_status_d   = final_status_q;
    cap_byte         = 8'd0;
    cap_valid        = 1'b0;
    if (step_i) begin
      unique case (command_i)
        mrw_pkg::CmdStart: begin
          match_index_d    = 4'd0;
          error_index_d    = 3'd0;
          captured_count_d = 8'd0;
          ticks_left_d     = cfg_i.timeout_ticks;
          phase_d          = mrw_pkg::PhMatch;
          final_status_d   = mrw_pkg::StBusy;
          if (eff_len == 4'd0) begin
            if (cfg_i.capture_limit == 8'd0) begin
              phase_d        = mrw_pkg::PhDone;
              final_status_d = mrw_pkg::StMatched;
            end else begin
              phase_d        = mrw_pkg::PhCapture;
            end
          end
        end
        mrw_pkg::CmdByte: begin
          if (phase_q == mrw_pkg::PhMatch) begin
            match_index_d = mi;
            error_index_d = ei;
            if (ei >= mrw_pkg::ErrLen) begin
              phase_d        = mrw_pkg::PhDone;
              final_status_d = mrw_pkg::StError;
            end else if (mi >= eff_len) begin
              if (cfg_i.capture_limit == 8'd0) begin
                phase_d        = mrw_pkg::PhDone;
                final_status_d = mrw_pkg::StMatched;
              end else begin
                phase_d        = mrw_pkg::PhCapture;
                final_status_d = mrw_pkg::StBusy;
              end
            end
          end else if (phase_q == mrw_pkg::PhCapture) begin
            cap_byte         = rx_byte_i;
            cap_valid        = 1'b1;
            captured_count_d = cnt_inc;
            if (rx_byte_i == mrw_pkg::NewlineChar || cnt_inc == 8'd0 ||
                cnt_inc >= cfg_i.capture_limit) begin
              phase_d        = mrw_pkg::PhDone;
              final_status_d = mrw_pkg::StMatched;
            end
          end
        end
        mrw_pkg::CmdTick: begin
          if ((phase_q == mrw_pkg::PhMatch || phase_q == mrw_pkg::PhCapture) &&
              ticks_left_q != 32'd0) begin
            ticks_left_d = ticks_dec;
            if (ticks_dec == 32'd0) begin
              phase_d        = mrw_pkg::PhDone;
              final_status_d = mrw_pkg::StTimeout;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= mrw_pkg::PhIdle;
      match_index_q    <= 4'd0;
      error_index_q    <= 3'd0;
      ticks_left_q     <= 32'd0;
      captured_count_q <= 8'd0;
      final_status_q   <= mrw_pkg::StIdle;
    end else begin
      phase_q          <= phase_d;
      match_index_q    <= match_index_d;
      error_index_q    <= error_index_d;
      ticks_left_q     <= ticks_left_d;
      captured_count_q <= captured_count_d;
      final_status_q   <= final_status_d;
    end
  end

  assign res_o.status        = final_status_d;
  assign res_o.capture_byte  = cap_byte;
  assign res_o.capture_valid = cap_valid;

endmodule

// ===== hw/rtl/modem_response_watcher.sv =====
// Top level of the modem response watcher: beat registers, config file and watcher core.
//
// The watcher takes one beat per cycle while in_stall_o is low (start, received byte or timer
// tick) and returns exactly one result beat per input beat, in order. A beat lands in an input
// register, the core updates its state and forms the result combinationally, and the result
// sits in an output register; one beat per cycle is sustained while the output is not stalled.
// The input register can still take a beat while a result waits at a stalled output;
// in_stall_o rises only when both registers are full and the output is stalled.
// Configuration writes are always ready and take effect in the next cycle; write them only
// while no beat is in flight.
module modem_response_watcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  capture_byte_o,
  output logic        capture_valid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  mrw_pkg::cfg_t cfg;
  mrw_pkg::res_t res;

  logic       in_vld_q, in_vld_d;
  logic [1:0] in_cmd_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  mrw_pkg::res_t out_q;
  logic       in_acc;
  logic       adv;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_cmd_q  <= command_i;
      in_byte_q <= rx_byte_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  mrw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mrw_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .command_i (in_cmd_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_q.status;
  assign capture_byte_o  = out_q.capture_byte;
  assign capture_valid_o = out_q.capture_valid;

  // a held beat in the input register must survive until it advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_cmd_q) && $stable(in_byte_q))
    else $error("held input beat lost or changed");

  // a beat handed to the core shows up at the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced beat missing at output");

  // captured bytes come only with a busy status, or a matched status on the closing capture byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && capture_valid_o |->
      status_o == mrw_pkg::StBusy || status_o == mrw_pkg::StMatched)
    else $error("capture beat with wrong status");

  // no capture means a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !capture_valid_o |-> capture_byte_o == 8'd0)
    else $error("stray capture byte");

endmodule
